// ===== sv/rtph_pkg.sv =====
// shared types and constants for the rtp h.264 depacketizer
// no dependencies; imported by every module of the block

package rtph_pkg;

    localparam int unsigned POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A = 5'd28;
    localparam logic [4:0] NAL_FU_B = 5'd29;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE = 8'h01;

    // start code bytes 0..3 then the header byte at step 4
    localparam logic [2:0] STEP_SC_ONE = 3'd3;
    localparam logic [2:0] STEP_HDR = 3'd4;

    typedef enum logic [1:0] {
        MODE_DROP  = 2'd0,
        MODE_PASS  = 2'd1,
        MODE_FUHDR = 2'd2
    } mode_t;

    // one queued command: a single pass byte, or a start code plus header
    typedef struct packed {
        logic       is_start;
        logic [7:0] data;
    } cmd_t;

endpackage

// ===== sv/rtp_h264_depacketizer.sv =====
// top level of the rtp to h.264 annex-b depacketizer
// depends on rtph_pkg, rtph_front, rtph_fifo, rtph_back
//
// input channel: push/full queue port, one packet byte per transaction with
// in_last on the final byte of the packet. the first RTP_HEADER_BYTES bytes
// are dropped, the next byte is the nal header.
// output channel: empty/pop queue port; out_byte is the stream byte,
// nal_start flags the first 00 of a start code, run_last the last byte made
// from one input byte.
// a single nal header or an fu header with s set and e clear gives five
// output bytes (00 00 00 01 hdr); each payload byte gives one.
// an input transaction passes the command queue and then the back part's command register before its first result.
// throughput: one input byte per cycle while the output is popped every cycle;
// the back part emits one byte per cycle, so a start code holds it for five
// output bytes and the command queue of FIFO_DEPTH entries absorbs the burst.
// when the receiver stalls, the queue fills and full rises.
// reset clears position, mode, saved indicator bits, the queue and the output.

module rtp_h264_depacketizer
    import rtph_pkg::*;
#(
    parameter int unsigned RTP_HEADER_BYTES = 12,
    parameter int unsigned FIFO_DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       nal_start,
    output logic       run_last
);

    logic q_full;
    logic q_wr;
    cmd_t q_wdata;
    logic q_rd;
    cmd_t q_rdata;
    logic q_empty;

    rtph_front #(
        .RTP_HEADER_BYTES(RTP_HEADER_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_byte (in_byte),
        .in_last (in_last),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_wdata (q_wdata)
    );

    rtph_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .rdata   (q_rdata),
        .q_empty (q_empty)
    );

    rtph_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .nal_start (nal_start),
        .run_last  (run_last)
    );

endmodule

// ===== sv/rtph_front.sv =====
// front part: accepts packet bytes, tracks position and mode, emits commands
// depends on rtph_pkg

module rtph_front
    import rtph_pkg::*;
#(
    parameter int unsigned RTP_HEADER_BYTES = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       q_wr,
    output cmd_t       q_wdata
);

    localparam logic [POS_W-1:0] HPOS = POS_W'(RTP_HEADER_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    mode_t            mode_reg;
    mode_t            mode_next;
    logic [2:0]       ind_reg;
    logic [2:0]       ind_next;
    logic             accept;
    logic [4:0]       nal_type;

    assign full     = q_full;
    assign accept   = push && !q_full;
    assign nal_type = in_byte[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            mode_reg <= MODE_DROP;
            ind_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            ind_reg  <= ind_next;
        end
    end

    // next state
    always_comb
    begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        ind_next  = ind_reg;
        if (accept)
        begin
            if (pos_reg == HPOS)
            begin
                unique case (nal_type) inside
                    [NAL_SINGLE_MIN:NAL_SINGLE_MAX]: mode_next = MODE_PASS;
                    NAL_FU_A, NAL_FU_B:
                    begin
                        mode_next = MODE_FUHDR;
                        ind_next  = in_byte[7:5];
                    end
                    default: mode_next = MODE_DROP;
                endcase
            end
            else if (pos_reg > HPOS)
            begin
                unique case (mode_reg)
                    MODE_FUHDR: mode_next = MODE_PASS;
                    default:    mode_next = mode_reg;
                endcase
            end
            if (in_last)
            begin
                pos_next  = '0;
                mode_next = MODE_DROP;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // command output
    always_comb
    begin
        q_wr             = 1'b0;
        q_wdata.is_start = 1'b0;
        q_wdata.data     = in_byte;
        if (accept)
        begin
            if (pos_reg == HPOS)
            begin
                if (nal_type >= NAL_SINGLE_MIN && nal_type <= NAL_SINGLE_MAX)
                begin
                    q_wr             = 1'b1;
                    q_wdata.is_start = 1'b1;
                end
            end
            else if (pos_reg > HPOS)
            begin
                unique case (mode_reg)
                    MODE_FUHDR:
                    begin
                        // start bit set and end bit clear
                        if (in_byte[7] && !in_byte[6])
                        begin
                            q_wr             = 1'b1;
                            q_wdata.is_start = 1'b1;
                            q_wdata.data     = {ind_reg, in_byte[4:0]};
                        end
                    end
                    MODE_PASS: q_wr = 1'b1;
                    default:   q_wr = 1'b0;
                endcase
            end
        end
    end

endmodule

// ===== sv/rtph_fifo.sv =====
// small command queue between the front and back parts
// depends on rtph_pkg

module rtph_fifo
    import rtph_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    output logic q_full,
    input  logic rd,
    output cmd_t rdata,
    output logic q_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

// ===== sv/rtph_back.sv =====
// back part: expands queued commands into annex-b stream bytes
// depends on rtph_pkg

module rtph_back
    import rtph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_rdata,
    output logic       q_rd,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       nal_start,
    output logic       run_last
);

    logic       valid_reg;
    logic       valid_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       take;
    logic       done;

    assign empty = !valid_reg;
    assign take  = valid_reg && pop;
    assign done  = !cmd_reg.is_start || (step_reg == STEP_HDR);
    // load a new command when idle or when the current one finishes
    assign q_rd  = !q_empty && (!valid_reg || (take && done));

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        if (q_rd)
        begin
            valid_next = 1'b1;
            cmd_next   = q_rdata;
            step_next  = '0;
        end
        else if (take)
        begin
            if (done)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_comb
    begin
        if (!cmd_reg.is_start || step_reg == STEP_HDR)
        begin
            out_byte = cmd_reg.data;
        end
        else if (step_reg == STEP_SC_ONE)
        begin
            out_byte = SC_ONE;
        end
        else
        begin
            out_byte = SC_ZERO;
        end
    end

    assign nal_start = cmd_reg.is_start && (step_reg == '0);
    assign run_last  = done;

endmodule

// ===== sv/rtph_checker.sv =====
// port-level checks for the rtp h.264 depacketizer, bound to the top level
// depends on rtp_h264_depacketizer

module rtph_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       nal_start,
    input logic       run_last
);

    // nothing leaves the block while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result visible during reset");

    // a start code opens with a zero byte and never ends a run
    a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && nal_start) |-> (out_byte == 8'h00 && !run_last))
        else $error("bad start code head");

    // the byte after the start code head is its second zero
    a_start_second: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && nal_start) |=>
            (!empty && out_byte == 8'h00 && !nal_start && !run_last))
        else $error("start code broken after first byte");

    // a waiting result is not withdrawn
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped while stalled");

endmodule

bind rtp_h264_depacketizer rtph_checker u_chk (.*);
